FILE: sv/hsfd_pkg.sv
// Shared types, constants and the CRC-8 step for the humidity sensor frame decoder.
// Used by hsfd_frame, hsfd_scale and the top level; depends on nothing else.
package hsfd_pkg;

   // Byte positions inside one six-byte reading.
   localparam logic [2:0] POS_TEMP_MSB = 3'd0;
   localparam logic [2:0] POS_TEMP_LSB = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_MSB  = 3'd3;
   localparam logic [2:0] POS_HUM_LSB  = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;

   localparam logic [7:0] CRC_INIT     = 8'hFF;
   localparam logic [7:0] CRC_POLY_RST = 8'h31;

   // Scale factors: 175.00 degrees span and 100.00 percent span, in hundredths.
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [16:0] FULL_SCALE  = 17'd65535;

   // Raw words and their products with the scale factors, with the error flag.
   typedef struct packed {
      logic [30:0] temp_product;
      logic [29:0] hum_product;
      logic [15:0] raw_temperature;
      logic [15:0] raw_humidity;
      logic        crc_error;
   } frame_type;

   // One CRC-8 byte step, MSB first.
   function automatic logic [7:0] crc_step(input logic [7:0] rem,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
      logic [7:0] r;
      r = rem ^ data;
      for (int k = 0; k < 8; k++) begin
         if (r[7]) begin
            r = {r[6:0], 1'b0} ^ poly;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

FILE: sv/hsfd_frame.sv
// Frame tracker: byte position, CRC checks and raw word assembly, plus the
// scale multiplications registered at the end of a frame. Depends on hsfd_pkg.
module hsfd_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [7:0]            csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   output logic                  frame_valid,
   input  logic                  frame_ready,
   output hsfd_pkg::frame_type   frame_data
);

   logic [7:0]          poly_ff, poly_in;
   logic [2:0]          pos_ff, pos_in;
   logic [7:0]          crc_ff, crc_in;
   logic [15:0]         temp_word_ff, temp_word_in;
   logic [15:0]         hum_word_ff, hum_word_in;
   logic                err_ff, err_in;
   logic                out_valid_ff, out_valid_in;
   hsfd_pkg::frame_type out_ff, out_in;

   logic                accept;
   logic [2:0]          pos_eff;
   logic                final_err;

   // A beat is taken whenever the frame slot is free or drains this cycle.
   assign req_tready = !out_valid_ff || frame_ready;
   assign accept     = req_tvalid && req_tready;

   // The first-byte flag and the unused positions both restart the frame.
   assign pos_eff   = (req_tuser || (pos_ff inside {[3'd6:3'd7]})) ?
                      hsfd_pkg::POS_TEMP_MSB : pos_ff;
   assign final_err = err_ff || (crc_ff != req_tdata);

   // Frame state update for one accepted beat.
   always_comb begin
      poly_in      = csr_wen ? csr_wdata : poly_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      err_in       = err_ff;
      out_valid_in = frame_ready ? 1'b0 : out_valid_ff;
      out_in       = out_ff;
      if (accept) begin
         pos_in = pos_eff + 3'd1;
         case (pos_eff)
            hsfd_pkg::POS_TEMP_MSB: begin
               err_in       = 1'b0;
               crc_in       = hsfd_pkg::crc_step(hsfd_pkg::CRC_INIT, req_tdata, poly_ff);
               temp_word_in = {req_tdata, temp_word_ff[7:0]};
            end
            hsfd_pkg::POS_TEMP_LSB: begin
               crc_in       = hsfd_pkg::crc_step(crc_ff, req_tdata, poly_ff);
               temp_word_in = {temp_word_ff[15:8], req_tdata};
            end
            hsfd_pkg::POS_TEMP_CRC: begin
               if (crc_ff != req_tdata) begin
                  err_in = 1'b1;
               end
            end
            hsfd_pkg::POS_HUM_MSB: begin
               crc_in      = hsfd_pkg::crc_step(hsfd_pkg::CRC_INIT, req_tdata, poly_ff);
               hum_word_in = {req_tdata, hum_word_ff[7:0]};
            end
            hsfd_pkg::POS_HUM_LSB: begin
               crc_in      = hsfd_pkg::crc_step(crc_ff, req_tdata, poly_ff);
               hum_word_in = {hum_word_ff[15:8], req_tdata};
            end
            default: begin
               // Last byte: close the frame and hand it on for scaling.
               err_in                 = final_err;
               crc_in                 = hsfd_pkg::CRC_INIT;
               pos_in                 = hsfd_pkg::POS_TEMP_MSB;
               out_valid_in           = 1'b1;
               out_in.temp_product    = 31'(temp_word_ff) * 31'(hsfd_pkg::TEMP_SCALE);
               out_in.hum_product     = 30'(hum_word_ff) * 30'(hsfd_pkg::HUM_SCALE);
               out_in.raw_temperature = temp_word_ff;
               out_in.raw_humidity    = hum_word_ff;
               out_in.crc_error       = final_err;
            end
         endcase
      end
   end

   // Control and frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff      <= hsfd_pkg::CRC_POLY_RST;
         pos_ff       <= hsfd_pkg::POS_TEMP_MSB;
         crc_ff       <= hsfd_pkg::CRC_INIT;
         temp_word_ff <= '0;
         hum_word_ff  <= '0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         poly_ff      <= poly_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_word_ff <= temp_word_in;
         hum_word_ff  <= hum_word_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Frame payload register.
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign frame_valid = out_valid_ff;
   assign frame_data  = out_ff;

endmodule

FILE: sv/hsfd_scale.sv
// Scaling stage: divides the registered products by 65535 and applies the
// offset and error masking into the result register. Depends on hsfd_pkg.
module hsfd_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  frame_valid,
   output logic                  frame_ready,
   input  hsfd_pkg::frame_type   frame_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,
   output logic                  rsp_tuser
);

   logic        valid_ff, valid_in;
   logic [63:0] data_ff, data_in;
   logic        err_ff, err_in;

   logic [14:0] temp_q0;
   logic [16:0] temp_rem;
   logic [14:0] temp_q;
   logic [15:0] temp_signed;
   logic [13:0] hum_q0;
   logic [16:0] hum_rem;
   logic [13:0] hum_q;
   logic [14:0] temp_out;
   logic [13:0] hum_out;

   // The result register takes a new beat when empty or drained this cycle.
   assign frame_ready = !valid_ff || rsp_tready;

   // Divide by 2^16-1: quotient estimate x>>16, remainder (x mod 2^16) + estimate,
   // which stays below twice the divisor, so one correction step is enough.
   always_comb begin
      temp_q0     = frame_data.temp_product[30:16];
      temp_rem    = {1'b0, frame_data.temp_product[15:0]} + 17'(temp_q0);
      temp_q      = temp_q0 + 15'(temp_rem >= hsfd_pkg::FULL_SCALE);
      temp_signed = {1'b0, temp_q} - hsfd_pkg::TEMP_OFFSET;
      hum_q0      = frame_data.hum_product[29:16];
      hum_rem     = {1'b0, frame_data.hum_product[15:0]} + 17'(hum_q0);
      hum_q       = hum_q0 + 14'(hum_rem >= hsfd_pkg::FULL_SCALE);
      temp_out    = frame_data.crc_error ? 15'd0 : temp_signed[14:0];
      hum_out     = frame_data.crc_error ? 14'd0 : hum_q;
   end

   // Result register load and drain.
   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      err_in   = err_ff;
      if (frame_valid && frame_ready) begin
         valid_in = 1'b1;
         data_in  = {3'b000, frame_data.raw_humidity, frame_data.raw_temperature,
                     hum_out, temp_out};
         err_in   = frame_data.crc_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = err_ff;

endmodule

FILE: sv/humidity_sensor_frame_decoder_unit.sv
// Pipeline: two register stages; the frame register loads the scale products at the edge that
// takes the sixth byte of a frame, and the result register then takes them and offers the
// result beat.
// Throughput: one byte per cycle; bytes stall only while a finished reading waits behind
// a result beat that rsp_tready holds back. The CRC step is unrolled over the byte.
// Reset (synchronous, active high) clears the byte position, CRC, words and error flag,
// empties both registers and sets the polynomial to 0x31. Depends on hsfd_pkg, hsfd_frame
// and hsfd_scale.
module humidity_sensor_frame_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   // Polynomial register write port.
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata,
   // Byte input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first_byte
   // Reading output.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
                                    // [44:29] raw_temperature, [60:45] raw_humidity,
                                    // [63:61] zero
   output logic        rsp_tuser    // [0] crc_error
);

   logic                frame_valid;
   logic                frame_ready;
   hsfd_pkg::frame_type frame_data;

   // Byte tracking and CRC checks.
   hsfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame_data  (frame_data)
   );

   // Scaling and result register.
   hsfd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame_data  (frame_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

FILE: bench/hsfd_reading_checker.sv
// Checker for the humidity sensor frame decoder: watches the byte, result and
// polynomial ports, predicts each reading and compares it with what arrives.
// Depends on hsfd_pkg for the byte positions and the CRC constants.
module hsfd_reading_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
                                    // [44:29] raw_temperature, [60:45] raw_humidity,
                                    // [63:61] zero
   input  logic        rsp_tuser,   // [0] crc_error
   output int          fail_count,
   output int          pending
);

   // One decoded reading as it should leave the block.
   typedef struct packed {
      logic [14:0] temp_centi;
      logic [13:0] hum_centi;
      logic [15:0] raw_temp;
      logic [15:0] raw_hum;
      logic        crc_error;
   } reading_type;

   reading_type expected_readings[$];
   int          errors = 0;

   // Shadow of the decoder state and its polynomial register.
   logic [7:0]  crc_poly;
   logic [2:0]  frame_pos;
   logic [7:0]  crc_rem;
   logic [15:0] temp_word;
   logic [15:0] hum_word;
   logic        check_failed;

   // CRC-8 over one byte, MSB first, with the current polynomial.
   function automatic logic [7:0] crc8_update(input logic [7:0] rem, input logic [7:0] b);
      logic [7:0] r;
      r = rem ^ b;
      repeat (8) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ crc_poly) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

   // Advance the frame by one byte and queue a reading after the last byte.
   task automatic decode_byte(input logic [7:0] b, input logic first);
      logic [2:0]  pos;
      logic        fail;
      int unsigned temp_prod;
      int unsigned hum_prod;
      int          temp_val;
      reading_type r;
      pos = (first || frame_pos > hsfd_pkg::POS_HUM_CRC) ? hsfd_pkg::POS_TEMP_MSB : frame_pos;
      case (pos)
         hsfd_pkg::POS_TEMP_MSB: begin
            check_failed = 1'b0;
            crc_rem = crc8_update(hsfd_pkg::CRC_INIT, b);
            temp_word[15:8] = b;
         end
         hsfd_pkg::POS_TEMP_LSB: begin
            crc_rem = crc8_update(crc_rem, b);
            temp_word[7:0] = b;
         end
         hsfd_pkg::POS_TEMP_CRC: begin
            if (crc_rem != b) check_failed = 1'b1;
         end
         hsfd_pkg::POS_HUM_MSB: begin
            crc_rem = crc8_update(hsfd_pkg::CRC_INIT, b);
            hum_word[15:8] = b;
         end
         hsfd_pkg::POS_HUM_LSB: begin
            crc_rem = crc8_update(crc_rem, b);
            hum_word[7:0] = b;
         end
         default: begin
            // Humidity CRC byte closes the frame and yields the reading.
            fail = check_failed | (crc_rem != b);
            temp_prod = 32'd17500 * temp_word;
            hum_prod = 32'd10000 * hum_word;
            temp_val = int'(temp_prod / 32'd65535) - 4500;
            r.temp_centi = fail ? 15'd0 : temp_val[14:0];
            r.hum_centi = fail ? 14'd0 : 14'(hum_prod / 32'd65535);
            r.raw_temp = temp_word;
            r.raw_hum = hum_word;
            r.crc_error = fail;
            expected_readings.push_back(r);
            check_failed = fail;
            crc_rem = hsfd_pkg::CRC_INIT;
            frame_pos = hsfd_pkg::POS_TEMP_MSB;
            return;
         end
      endcase
      frame_pos = pos + 3'd1;
   endtask

   task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   // Compare one result beat with the oldest expected reading.
   task automatic compare_reading();
      reading_type want;
      if (expected_readings.size() == 0) begin
         errors++;
         $display("%0t: unexpected reading, expected none, actual tdata %h tuser %b",
                  $time, rsp_tdata, rsp_tuser);
      end else begin
         want = expected_readings.pop_front();
         check_field("temperature_centi", 16'(want.temp_centi), 16'(rsp_tdata[14:0]));
         check_field("humidity_centi", 16'(want.hum_centi), 16'(rsp_tdata[28:15]));
         check_field("raw_temperature", want.raw_temp, rsp_tdata[44:29]);
         check_field("raw_humidity", want.raw_hum, rsp_tdata[60:45]);
         check_field("tdata padding", 16'd0, 16'(rsp_tdata[63:61]));
         check_field("crc_error", 16'(want.crc_error), 16'(rsp_tuser));
      end
   endtask

   // Results are checked before the byte of the same edge is absorbed; a byte taken
   // at the edge of a polynomial write still uses the old polynomial.
   always @(posedge clock) begin
      if (reset) begin
         crc_poly = hsfd_pkg::CRC_POLY_RST;
         frame_pos = hsfd_pkg::POS_TEMP_MSB;
         crc_rem = hsfd_pkg::CRC_INIT;
         temp_word = 16'd0;
         hum_word = 16'd0;
         check_failed = 1'b0;
         expected_readings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_reading();
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tuser);
         if (csr_wen) crc_poly = csr_wdata;
      end
      fail_count <= errors;
      pending <= expected_readings.size();
   end

endmodule

FILE: bench/tb_humidity_sensor_frame_decoder_unit.sv
// Top of the frame decoder testbench: clock, reset, byte frames, polynomial
// writes and result back-pressure, plus the final verdict.
// Depends on hsfd_pkg, humidity_sensor_frame_decoder_unit and hsfd_reading_checker.
module tb_humidity_sensor_frame_decoder_unit;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tuser = 1'b0;   // [0] first_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // [14:0] temperature_centi, [28:15] humidity_centi,
                                    // [44:29] raw_temperature, [60:45] raw_humidity,
                                    // [63:61] zero
   logic        rsp_tuser;          // [0] crc_error

   int          fail_count;
   int          pending;
   int          send_gap_pct = 0;
   int          recv_stall_pct = 0;
   int          beats_sent = 0;
   logic [7:0]  cur_poly = hsfd_pkg::CRC_POLY_RST;
   logic        frame_aligned = 1'b0;

   always #4 clock = ~clock;

   humidity_sensor_frame_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   hsfd_reading_checker chk (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Result back-pressure at the current stall rate.
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Offer one byte after a random gap and hold it until it is taken.
   task automatic push_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // Send the first count bytes of a frame; a CRC byte can be spoiled on purpose.
   task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw, input logic first,
                             input logic bad_t, input logic bad_h, input int count);
      logic [7:0] frame_bytes [6];
      frame_bytes[0] = tw[15:8];
      frame_bytes[1] = tw[7:0];
      frame_bytes[2] = hsfd_pkg::crc_step(hsfd_pkg::crc_step(hsfd_pkg::CRC_INIT, tw[15:8],
                                                             cur_poly), tw[7:0], cur_poly)
                       ^ (bad_t ? 8'($urandom_range(255, 1)) : 8'd0);
      frame_bytes[3] = hw[15:8];
      frame_bytes[4] = hw[7:0];
      frame_bytes[5] = hsfd_pkg::crc_step(hsfd_pkg::crc_step(hsfd_pkg::CRC_INIT, hw[15:8],
                                                             cur_poly), hw[7:0], cur_poly)
                       ^ (bad_h ? 8'($urandom_range(255, 1)) : 8'd0);
      for (int i = 0; i < count; i++) begin
         push_byte(frame_bytes[i], (i == 0) ? first : 1'b0);
      end
      frame_aligned = (count == 6);
   endtask

   // Wait until every reading is out and the pipeline has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_poly(input logic [7:0] p);
      csr_wen <= 1'b1;
      csr_wdata <= p;
      @(posedge clock);
      csr_wen <= 1'b0;
      cur_poly = p;
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly whole frames with random content, some cut short, some noise.
   task automatic random_traffic(input int beats);
      int kind;
      int stop_at;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            send_frame(pick_word(), pick_word(), frame_aligned ? 1'($urandom) : 1'b1,
                       $urandom_range(99) < 15, $urandom_range(99) < 15, 6);
         end else if (kind < 90) begin
            send_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0, $urandom_range(5, 1));
         end else begin
            repeat ($urandom_range(4, 1)) push_byte(8'($urandom), 1'($urandom));
            frame_aligned = 1'b0;
         end
      end
   endtask

   initial begin
      logic [7:0] phase_poly [6];
      phase_poly = '{hsfd_pkg::CRC_POLY_RST, 8'h00, 8'hFF, 8'h00, 8'h00,
                     hsfd_pkg::CRC_POLY_RST};
      phase_poly[3] = 8'($urandom);
      phase_poly[4] = 8'($urandom);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 6; phase++) begin
         // Receiver-heavy stalls, then sender-heavy gaps, then full speed.
         case (phase / 2)
            0: begin send_gap_pct = 27; recv_stall_pct = 56; end
            1: begin send_gap_pct = 56; recv_stall_pct = 27; end
            default: begin send_gap_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase != 0) write_poly(phase_poly[phase]);
         if (phase == 0) begin
            // All-zero and all-ones words, the second frame back to back.
            send_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 6);
            send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
            // A partial frame dropped by a resync that fails both checks.
            send_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0, 2);
            send_frame(16'h6666, 16'h9999, 1'b1, 1'b1, 1'b1, 6);
         end
         random_traffic(115);
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
